FILE: hdl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and opcodes for the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Request opcodes; codes 6 and 7 carry no meaning and are ignored.
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_SINGLE = 3'd1,
        OP_MULTI  = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_PUSH   = 3'd4,
        OP_START  = 3'd5
    } opcode_t;

    localparam int DUR_W = 8;
    localparam int CNT_W = 8;
    localparam int POS_OUT_W = 5;

    // One request item.
    typedef struct packed {
        opcode_t            opcode;
        logic [DUR_W-1:0]   duration;
        logic [CNT_W-1:0]   repeat_count;
    } req_item_t;

    // One result item.
    typedef struct packed {
        logic                   buzzer_on;
        logic                   playing;
        logic [POS_OUT_W-1:0]   position;
    } rsp_item_t;

endpackage

FILE: hdl/bps_table.sv
// ----------------------------------------------------------------------------
// bps_table
// Duration table: a synchronous single-write, single-read memory with one
// valid bit per entry, so that reset and the clear command empty it at once.
// ----------------------------------------------------------------------------
module bps_table #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [bps_pkg::DUR_W-1:0]           rd_data,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [bps_pkg::DUR_W-1:0]           wr_data,
    input  logic                                clr
);

    logic [bps_pkg::DUR_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [bps_pkg::DUR_W-1:0]  rd_data_reg;
    logic                       rd_valid_reg;

    // Storage array and its registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: an entry that was never written since the last clear reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Buzzer pattern player built around a table of tick durations.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (req_valid/req_ready): a tick from a timer, or a
//   command from software (single beep, multiple beeps, clear, push, start).
//   Every request yields exactly one result on rsp (rsp_valid/rsp_ready)
//   carrying the buzzer level, the playing flag and the table position.
//   Commands other than tick are ignored while a pattern is playing.
//   An accepted request passes through the final stage, where its result is
//   registered; a multiple-beep load first sweeps the table, writing one entry
//   per step, up to TABLE_DEPTH entries. One request is in flight at a time,
//   so the block takes no new request until the current one has its result;
//   the table entry is read when a request is accepted and written back in the final stage.
//   A new request is accepted while an earlier result still waits on rsp.
//   If the receiver stalls, the finished request holds in the final stage
//   until the waiting result has been taken.
//   Reset clears the table (through per-entry valid bits, no clearing pass),
//   rewinds the position to zero, and leaves the player idle and silent.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bps_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bps_pkg::rsp_item_t  rsp
);

    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);
    localparam logic [bps_pkg::CNT_W:0] DEPTH_N = (bps_pkg::CNT_W + 1)'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_EXEC
    } state_t;

    state_t                     state_reg, state_next;
    bps_pkg::req_item_t         req_reg, req_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic                       active_reg, active_next;
    logic                       buzz_reg, buzz_next;
    logic [IW-1:0]              fill_cnt_reg, fill_cnt_next;
    logic [IW-1:0]              fill_last_reg, fill_last_next;
    bps_pkg::rsp_item_t         rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic                       accept;
    logic                       commit;
    logic                       pos_in_range;
    logic [IW-1:0]              pos_idx;
    logic [PW-1:0]              pos_plus;
    logic [bps_pkg::CNT_W:0]    fill_n;
    logic [PW+bps_pkg::POS_OUT_W-1:0] pos_ext;

    logic                       tbl_wr_en;
    logic [IW-1:0]              tbl_wr_addr;
    logic [bps_pkg::DUR_W-1:0]  tbl_wr_data;
    logic                       tbl_clr;
    logic [bps_pkg::DUR_W-1:0]  tbl_rd_data;

    // Handshake and position helpers.
    assign req_ready    = (state_reg == S_IDLE);
    assign accept       = req_valid && req_ready;
    assign commit       = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign pos_in_range = (pos_reg < DEPTH_P);
    assign pos_idx      = pos_in_range ? pos_reg[IW-1:0] : '0;
    assign pos_plus     = pos_reg + 1'b1;
    assign fill_n       = {req.repeat_count, 1'b0};
    assign pos_ext      = {{bps_pkg::POS_OUT_W{1'b0}}, pos_next};

    // The entry at the current position is read when a request is accepted.
    bps_table #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (pos_idx),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .clr     (tbl_clr)
    );

    // Next-state logic: table sweep for multiple beeps, then the final update.
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        active_next    = active_reg;
        buzz_next      = buzz_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_last_next = fill_last_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = pos_idx;
        tbl_wr_data    = req_reg.duration;
        tbl_clr        = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    if ((req.opcode == bps_pkg::OP_MULTI) && !active_reg &&
                        (fill_n != '0))
                    begin
                        fill_cnt_next  = '0;
                        fill_last_next = (fill_n >= DEPTH_N) ? LAST_IDX
                                                             : IW'(fill_n - 1'b1);
                        state_next     = S_FILL;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end

            S_FILL:
            begin
                tbl_wr_en     = 1'b1;
                tbl_wr_addr   = fill_cnt_reg;
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == fill_last_reg)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (commit)
                begin
                    if (req_reg.opcode == bps_pkg::OP_TICK)
                    begin
                        if (!active_reg)
                        begin
                            buzz_next = 1'b0;
                        end
                        else if (!pos_in_range)
                        begin
                            pos_next    = '0;
                            active_next = 1'b0;
                            buzz_next   = 1'b0;
                        end
                        else
                        begin
                            buzz_next = !pos_reg[0];
                            if (tbl_rd_data != '0)
                            begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_data = tbl_rd_data - 1'b1;
                            end
                            else if (pos_plus == DEPTH_P)
                            begin
                                pos_next    = '0;
                                active_next = 1'b0;
                            end
                            else
                            begin
                                pos_next = pos_plus;
                            end
                        end
                    end
                    else if (!active_reg)
                    begin
                        unique case (req_reg.opcode)
                            bps_pkg::OP_SINGLE:
                            begin
                                tbl_wr_en   = 1'b1;
                                tbl_wr_addr = '0;
                                active_next = 1'b1;
                            end
                            bps_pkg::OP_MULTI:
                            begin
                                active_next = 1'b1;
                            end
                            bps_pkg::OP_CLEAR:
                            begin
                                tbl_clr  = 1'b1;
                                pos_next = '0;
                            end
                            bps_pkg::OP_PUSH:
                            begin
                                if (pos_in_range)
                                begin
                                    tbl_wr_en = 1'b1;
                                    pos_next  = pos_plus;
                                end
                            end
                            bps_pkg::OP_START:
                            begin
                                active_next = 1'b1;
                                pos_next    = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    rsp_next.buzzer_on = buzz_next;
                    rsp_next.playing   = active_next;
                    rsp_next.position  = pos_ext[bps_pkg::POS_OUT_W-1:0];
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            active_reg    <= 1'b0;
            buzz_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            fill_last_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            active_reg    <= active_next;
            buzz_reg      <= buzz_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_last_reg <= fill_last_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    // The position never runs past the end of the table.
    assert property (@(posedge clk) disable iff (!rst_n) pos_reg <= DEPTH_P)
        else $error("table position beyond table depth");

    // A table sweep only runs while the player is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !active_reg)
        else $error("table sweep while playing");

    // The sweep counter stays within the span being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (fill_cnt_reg <= fill_last_reg))
        else $error("sweep counter past its last entry");

    // An accepted request moves on to the table sweep or to the final stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_FILL) || (state_reg == S_EXEC))
        else $error("accepted request did not leave the idle state");

    // A table write never coincides with a clear.
    assert property (@(posedge clk) disable iff (!rst_n) !(tbl_wr_en && tbl_clr))
        else $error("table write and clear in the same cycle");
`endif

endmodule
